// ----- sv/fmf_pkg.sv -----
// ----------------------------------------------------------------------------
// fmf_pkg
// Shared constants and types of the frame multiplicity filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fmf_pkg;

  localparam int MAX_POINTS       = 32;
  localparam int PAYLOAD_BITS     = 48;
  localparam int FRAME_BITS       = 32;
  localparam int OUT_PAYLOAD_BITS = 48;
  localparam int PW_BITS          = 6;
  localparam int COUNT_BITS       = $clog2(MAX_POINTS + 1);
  localparam int ADDR_BITS        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic REG_POINTS_WANTED = 1'b0;
  localparam logic [PW_BITS-1:0] POINTS_RESET = PW_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_START
  } st_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_BITS-1:0]    waddr;
    logic [PAYLOAD_BITS-1:0] wdata;
    logic                    re;
    logic [ADDR_BITS-1:0]    raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- sv/fmf_row_ram.sv -----
// ----------------------------------------------------------------------------
// fmf_row_ram
// Row payload store: one write and one registered read port, read data held
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module fmf_row_ram
  import fmf_pkg::*;
(
  input  wire logic                    clk,
  input  wire ram_req_t                req,
  output logic [PAYLOAD_BITS-1:0]      rdata
);

  logic [PAYLOAD_BITS-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// fmf_ctrl
// Frame tracking, row buffering and drain sequencer of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module fmf_ctrl
  import fmf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [PW_BITS-1:0]      points_wanted,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [FRAME_BITS-1:0]   frame_number,
  input  wire logic [47:0]             row_payload,
  input  wire logic                    end_of_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [FRAME_BITS-1:0]        out_frame_number,
  output logic                         last_of_frame,
  output ram_req_t                     ram_req
);

  st_t                     state, state_next;
  logic [FRAME_BITS-1:0]   cur_frame, cur_frame_next;
  logic [COUNT_BITS-1:0]   rows, rows_next;
  logic                    open, open_next;
  logic                    ovf, ovf_next;
  logic [FRAME_BITS-1:0]   drn_frame, drn_frame_next;
  logic [COUNT_BITS-1:0]   drn_count, drn_count_next;
  logic [ADDR_BITS-1:0]    rd_idx, rd_idx_next;
  logic                    pend, pend_next;
  logic [FRAME_BITS-1:0]   pend_frame, pend_frame_next;
  logic [PAYLOAD_BITS-1:0] pend_payload, pend_payload_next;
  logic                    pend_eod, pend_eod_next;
  logic                    out_valid_r, out_valid_next;
  logic [FRAME_BITS-1:0]   out_frame_r, out_frame_next;
  logic                    out_last_r, out_last_next;

  logic                    accept;
  logic                    same;
  logic                    room;
  logic [COUNT_BITS-1:0]   rows_inc;
  logic                    same_eod_pass;
  logic                    old_pass;
  logic                    pw_one;
  logic                    out_free;
  logic                    rd_issue;
  logic                    rd_last;
  logic [PAYLOAD_BITS-1:0] in_payload;

  assign in_stall      = (state != ST_IDLE);
  assign accept        = in_valid && (state == ST_IDLE);
  assign in_payload    = PAYLOAD_BITS'(row_payload);
  assign same          = open && (frame_number == cur_frame);
  assign room          = rows < COUNT_BITS'(MAX_POINTS);
  assign rows_inc      = rows + COUNT_BITS'(1);
  assign same_eod_pass = !ovf && room && (PW_BITS'(rows_inc) == points_wanted);
  assign old_pass      = open && !ovf && (PW_BITS'(rows) == points_wanted);
  assign pw_one        = (points_wanted == PW_BITS'(1));
  assign out_free      = !out_valid_r || !out_stall;
  assign rd_issue      = (state == ST_DRAIN) && out_free;
  assign rd_last       = (COUNT_BITS'(rd_idx) + COUNT_BITS'(1)) == drn_count;

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_frame_r;
  assign last_of_frame    = out_last_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (same) begin
            if (end_of_data && same_eod_pass) begin
              state_next = ST_DRAIN;
            end
          end else if (old_pass) begin
            state_next = ST_DRAIN;
          end else if (end_of_data && pw_one) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_issue && rd_last) begin
          state_next = pend ? ST_START : ST_IDLE;
        end
      end
      ST_START: begin
        state_next = (pend_eod && pw_one) ? ST_DRAIN : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cur_frame_next    = cur_frame;
    rows_next         = rows;
    open_next         = open;
    ovf_next          = ovf;
    drn_frame_next    = drn_frame;
    drn_count_next    = drn_count;
    rd_idx_next       = rd_idx;
    pend_next         = pend;
    pend_frame_next   = pend_frame;
    pend_payload_next = pend_payload;
    pend_eod_next     = pend_eod;
    out_valid_next    = out_valid_r && out_stall;
    out_frame_next    = out_frame_r;
    out_last_next     = out_last_r;
    ram_req           = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (same) begin
            if (room) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = ADDR_BITS'(rows);
              ram_req.wdata = in_payload;
              rows_next     = rows_inc;
            end else begin
              ovf_next = 1'b1;
            end
            if (end_of_data) begin
              open_next = 1'b0;
              rows_next = '0;
              ovf_next  = 1'b0;
              if (same_eod_pass) begin
                drn_frame_next = cur_frame;
                drn_count_next = rows_inc;
                rd_idx_next    = '0;
              end
            end
          end else if (old_pass) begin
            drn_frame_next    = cur_frame;
            drn_count_next    = rows;
            rd_idx_next       = '0;
            pend_next         = 1'b1;
            pend_frame_next   = frame_number;
            pend_payload_next = in_payload;
            pend_eod_next     = end_of_data;
            open_next         = 1'b0;
            rows_next         = '0;
            ovf_next          = 1'b0;
          end else begin
            ram_req.we     = 1'b1;
            ram_req.waddr  = '0;
            ram_req.wdata  = in_payload;
            cur_frame_next = frame_number;
            ovf_next       = 1'b0;
            if (end_of_data) begin
              open_next = 1'b0;
              rows_next = '0;
              if (pw_one) begin
                drn_frame_next = frame_number;
                drn_count_next = COUNT_BITS'(1);
                rd_idx_next    = '0;
              end
            end else begin
              open_next = 1'b1;
              rows_next = COUNT_BITS'(1);
            end
          end
        end
      end
      ST_DRAIN: begin
        if (rd_issue) begin
          ram_req.re     = 1'b1;
          ram_req.raddr  = rd_idx;
          rd_idx_next    = rd_idx + ADDR_BITS'(1);
          out_valid_next = 1'b1;
          out_frame_next = drn_frame;
          out_last_next  = rd_last;
        end
      end
      ST_START: begin
        ram_req.we     = 1'b1;
        ram_req.waddr  = '0;
        ram_req.wdata  = pend_payload;
        cur_frame_next = pend_frame;
        pend_next      = 1'b0;
        ovf_next       = 1'b0;
        if (pend_eod) begin
          open_next = 1'b0;
          rows_next = '0;
          if (pw_one) begin
            drn_frame_next = pend_frame;
            drn_count_next = COUNT_BITS'(1);
            rd_idx_next    = '0;
          end
        end else begin
          open_next = 1'b1;
          rows_next = COUNT_BITS'(1);
        end
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_frame   <= '0;
      rows        <= '0;
      open        <= 1'b0;
      ovf         <= 1'b0;
      pend        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      cur_frame   <= cur_frame_next;
      rows        <= rows_next;
      open        <= open_next;
      ovf         <= ovf_next;
      pend        <= pend_next;
      out_valid_r <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    drn_frame    <= drn_frame_next;
    drn_count    <= drn_count_next;
    rd_idx       <= rd_idx_next;
    pend_frame   <= pend_frame_next;
    pend_payload <= pend_payload_next;
    pend_eod     <= pend_eod_next;
    out_frame_r  <= out_frame_next;
    out_last_r   <= out_last_next;
  end

endmodule

`default_nettype wire

// ----- sv/frame_multiplicity_filter.sv -----
// ----------------------------------------------------------------------------
// frame_multiplicity_filter
// Groups list-mode rows by frame number and passes only frames whose row
// count equals the programmed point count.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------
//   input    | in        | in_valid / in_stall | frame_number, row_payload,
//            |           |                     | end_of_data
//   output   | out       | out_valid/out_stall | out_frame_number, out_payload,
//            |           |                     | last_of_frame
//   config   | in        | apb psel/penable    | points_wanted at address 0
//
// A row that does not close a passing frame is accepted without a stall.
// A passing frame of n rows is read from the row memory at one row a cycle
// when out_stall is low; the input is stalled in the drain and start states.
// An end-of-data row starting a one-row frame with a count of one adds a
// further row read. Output stalls hold the drain through the read enable.
// Synchronous reset; the row memory has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_multiplicity_filter
  import fmf_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [PADDR_BITS-1:0]        paddr,
  input  wire logic [PDATA_BITS-1:0]        pwdata,
  output logic      [PDATA_BITS-1:0]        prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [FRAME_BITS-1:0]        frame_number,
  input  wire logic [47:0]                  row_payload,
  input  wire logic                         end_of_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [FRAME_BITS-1:0]        out_frame_number,
  output logic      [OUT_PAYLOAD_BITS-1:0]  out_payload,
  output logic                              last_of_frame
);

  logic [PW_BITS-1:0]      points_wanted;
  ram_req_t                ram_req;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_POINTS_WANTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_wanted <= POINTS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      points_wanted <= pwdata[PW_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_BITS'(points_wanted) : '0;

  fmf_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .points_wanted    (points_wanted),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .frame_number     (frame_number),
    .row_payload      (row_payload),
    .end_of_data      (end_of_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_number (out_frame_number),
    .last_of_frame    (last_of_frame),
    .ram_req          (ram_req)
  );

  fmf_row_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_payload = OUT_PAYLOAD_BITS'(ram_rdata);

endmodule

`default_nettype wire

// ----- sv/fmf_checker.sv -----
// ----------------------------------------------------------------------------
// fmf_checker
// Port-level checks of the frame multiplicity filter.
// ----------------------------------------------------------------------------
`default_nettype none

module fmf_checker
  import fmf_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [FRAME_BITS-1:0]       out_frame_number,
  input wire logic [OUT_PAYLOAD_BITS-1:0] out_payload,
  input wire logic                        last_of_frame
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_payload)
      && $stable(out_frame_number) && $stable(last_of_frame))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // rows of one passed frame share the frame number
  a_same_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame |=>
      !out_valid || (out_frame_number == $past(out_frame_number)))
    else $error("frame number changed inside a passed frame");

  // input held off while a frame is still draining
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_frame |-> in_stall)
    else $error("input accepted during frame drain");

endmodule

bind frame_multiplicity_filter fmf_checker u_fmf_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_number (out_frame_number),
  .out_payload      (out_payload),
  .last_of_frame    (last_of_frame)
);

`default_nettype wire
